FILE: hw/rtl/cesd_pkg.sv
// Shared types, constants and character helpers for the escape sequence decoder.
package cesd_pkg;

  localparam int CpW  = 21;
  localparam int ValW = 31;

  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  localparam logic [CpW-1:0] ChBackslash = CpW'(8'h5C);
  localparam logic [CpW-1:0] ChLowerX    = CpW'(8'h78);
  localparam logic [CpW-1:0] ChZero      = CpW'(8'h30);
  localparam logic [CpW-1:0] ChSeven     = CpW'(8'h37);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_OCT   = 2'd3
  } mode_e;

  // One queue entry: the results caused by one input item.
  typedef struct packed {
    logic            two;
    logic            last;
    logic            no_data;
    logic [ValW-1:0] v0;
    logic [ValW-1:0] v1;
  } entry_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] value;
  } esc_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } hex_t;

  function automatic esc_t simple_esc(input logic [CpW-1:0] c);
    esc_t r;
    r.hit = 1'b1;
    unique case (c)
      CpW'(8'h27): r.value = 7'h27;
      CpW'(8'h22): r.value = 7'h22;
      CpW'(8'h3F): r.value = 7'h3F;
      CpW'(8'h5C): r.value = 7'h5C;
      CpW'(8'h61): r.value = 7'h07; // a
      CpW'(8'h62): r.value = 7'h08; // b
      CpW'(8'h66): r.value = 7'h0C; // f
      CpW'(8'h6E): r.value = 7'h0A; // n
      CpW'(8'h72): r.value = 7'h0D; // r
      CpW'(8'h74): r.value = 7'h09; // t
      CpW'(8'h76): r.value = 7'h0B; // v
      default: begin
        r.hit   = 1'b0;
        r.value = 7'h00;
      end
    endcase
    return r;
  endfunction

  function automatic hex_t hex_digit(input logic [CpW-1:0] c);
    hex_t r;
    r.hit   = 1'b0;
    r.digit = 4'h0;
    if (c >= CpW'(8'h30) && c <= CpW'(8'h39)) begin
      r.hit   = 1'b1;
      r.digit = c[3:0];
    end else if ((c >= CpW'(8'h61) && c <= CpW'(8'h66)) ||
                 (c >= CpW'(8'h41) && c <= CpW'(8'h46))) begin
      r.hit   = 1'b1;
      r.digit = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cesd_front.sv
// Front end: scan-mode state machine, run accumulator and result classification.
module cesd_front import cesd_pkg::*; #(
  parameter int MAX_OCTAL_DIGITS = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [CpW-1:0] code_point_i,
  input  logic           last_in_i,
  output logic           wr_o,
  output entry_t         entry_o
);

  localparam logic [1:0] MaxCnt = MAX_OCTAL_DIGITS[1:0];

  mode_e           mode_q, mode_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;

  esc_t            esc;
  hex_t            hx;
  logic            is_oct;
  logic [2:0]      oct_d;
  logic [1:0]      cnt_inc;
  logic            pre_en, post_en, do_plain;
  logic [ValW-1:0] pre_v, post_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

  assign esc     = simple_esc(code_point_i);
  assign hx      = hex_digit(code_point_i);
  assign is_oct  = (code_point_i >= ChZero) && (code_point_i <= ChSeven);
  assign oct_d   = code_point_i[2:0];
  assign cnt_inc = cnt_q + 2'd1;

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    pre_en   = 1'b0;
    pre_v    = '0;
    post_en  = 1'b0;
    post_v   = '0;
    do_plain = 1'b0;

    unique case (mode_q)
      MODE_PLAIN: do_plain = 1'b1;
      MODE_ESC: begin
        if (esc.hit) begin
          pre_en = 1'b1;
          pre_v  = ValW'(esc.value);
          mode_d = MODE_PLAIN;
        end else if (code_point_i == ChLowerX) begin
          acc_d  = '0;
          mode_d = MODE_HEX;
        end else if (is_oct) begin
          acc_d  = ValW'(oct_d);
          cnt_d  = 2'd1;
          mode_d = MODE_OCT;
          if (MaxCnt <= 2'd1) begin
            pre_en = 1'b1;
            pre_v  = ValW'(oct_d);
            acc_d  = '0;
            cnt_d  = '0;
            mode_d = MODE_PLAIN;
          end
        end else begin
          pre_en   = 1'b1;
          mode_d   = MODE_PLAIN;
          do_plain = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hx.hit) begin
          // {acc, digit} overflows exactly when the top nibble is nonzero
          acc_d = (acc_q[ValW-1 -: 4] != 4'h0) ? ValMax : {acc_q[ValW-5:0], hx.digit};
        end else begin
          pre_en   = 1'b1;
          pre_v    = acc_q;
          acc_d    = '0;
          mode_d   = MODE_PLAIN;
          do_plain = 1'b1;
        end
      end
      MODE_OCT: begin
        if (is_oct && cnt_q < MaxCnt) begin
          acc_d = {acc_q[ValW-4:0], oct_d};
          cnt_d = cnt_inc;
          if (cnt_inc >= MaxCnt) begin
            pre_en = 1'b1;
            pre_v  = {acc_q[ValW-4:0], oct_d};
            acc_d  = '0;
            cnt_d  = '0;
            mode_d = MODE_PLAIN;
          end
        end else begin
          pre_en   = 1'b1;
          pre_v    = acc_q;
          acc_d    = '0;
          cnt_d    = '0;
          mode_d   = MODE_PLAIN;
          do_plain = 1'b1;
        end
      end
      default: mode_d = MODE_PLAIN;
    endcase

    if (do_plain) begin
      if (code_point_i == ChBackslash) begin
        mode_d = MODE_ESC;
      end else begin
        post_en = 1'b1;
        post_v  = ValW'(code_point_i);
      end
    end

    // end of string: flush an open run, drop a dangling backslash
    if (last_in_i) begin
      if (mode_d == MODE_HEX || mode_d == MODE_OCT) begin
        post_en = 1'b1;
        post_v  = acc_d;
      end
      mode_d = MODE_PLAIN;
      acc_d  = '0;
      cnt_d  = '0;
    end
  end

  always_comb begin
    entry_o.two     = pre_en && post_en;
    entry_o.last    = last_in_i;
    entry_o.no_data = !pre_en && !post_en;
    entry_o.v0      = pre_en ? pre_v : post_v;
    entry_o.v1      = post_v;
  end

  assign wr_o = accept_i && (pre_en || post_en || last_in_i);

endmodule

FILE: hw/rtl/cesd_queue.sv
// Short register queue of result entries between front and back end.
module cesd_queue import cesd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = PtrW + 1;

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  // depth is a power of two so pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  assign entry_o = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("read from empty queue");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after write");

endmodule

FILE: hw/rtl/cesd_back.sv
// Back end: splits each queue entry into one or two result transfers.
module cesd_back import cesd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  entry_t          entry_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [ValW-1:0] decoded_value_o,
  output logic            no_data_o,
  output logic            last_out_o
);

  logic phase_q;   // 1: first of two results already taken
  logic take;
  logic tail;

  assign take = pop_i && !q_empty_i;
  assign tail = !entry_i.two || phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (take) begin
      phase_q <= !tail;
    end
  end

  assign q_pop_o         = take && tail;
  assign empty_o         = q_empty_i;
  assign decoded_value_o = phase_q ? entry_i.v1 : entry_i.v0;
  assign no_data_o       = entry_i.no_data;
  assign last_out_o      = entry_i.last && tail;

  a_phase_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q && !q_empty_i) |-> entry_i.two)
    else $error("second result taken from single-result entry");

  a_nodata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && entry_i.no_data) |-> (entry_i.last && !entry_i.two))
    else $error("end-only entry without end mark");

  a_phase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> !phase_q)
    else $error("phase not cleared after entry retired");

endmodule

FILE: hw/rtl/c_escape_sequence_decoder_unit.sv
// A result becomes visible once its entry is registered in the queue and reaches the head.
// Throughput: one input item per cycle unless full; a two-result item takes two pops.
// The front end decodes each item in its accept cycle, writing at most one queue entry.
// The back end hands out one result per cycle from the queue head when popped.
// Reset (rst_ni low, async): scan state cleared, queue emptied, no results pending.
module c_escape_sequence_decoder_unit import cesd_pkg::*; #(
  parameter int MAX_OCTAL_DIGITS = 3,  // 1..3
  parameter int QUEUE_DEPTH      = 4   // power of two, at least 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input side
  input  logic            push,
  output logic            full,
  input  logic [CpW-1:0]  code_point_i,
  input  logic            last_in_i,
  // result side
  output logic            empty,
  input  logic            pop,
  output logic [ValW-1:0] decoded_value_o,
  output logic            no_data_o,
  output logic            last_out_o
);

  logic   accept;      // input transfer this cycle
  logic   q_wr;        // front end writes an entry
  entry_t q_wdata;
  entry_t q_rdata;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  // The queue full flag alone gates the input, so an item is taken while
  // earlier results still wait on the output side.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Front: mode register, hex/octal accumulator, classifies each code point
  // into zero, one or two results (or an end-only marker on the last item).
  cesd_front #(
    .MAX_OCTAL_DIGITS(MAX_OCTAL_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_point_i(code_point_i),
    .last_in_i   (last_in_i),
    .wr_o        (q_wr),
    .entry_o     (q_wdata)
  );

  // Decoupling queue: one entry per item that produced something or ended the string.
  cesd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_wr),
    .entry_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(q_rdata),
    .empty_o(q_empty)
  );

  // Back: serializes entries into result transfers, marks the final one.
  cesd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (q_rdata),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .decoded_value_o(decoded_value_o),
    .no_data_o      (no_data_o),
    .last_out_o     (last_out_o)
  );

endmodule
